FILE: rtl/tcc_pkg.sv
// tcc_pkg: shared constants and types for the tetrahedron circumcenter block
// no dependencies; used by tcc_mul, tcc_div and tetrahedron_circumcenter
package tcc_pkg;

	// default coordinate width, signed fixed point (Q16.16 at 32 bits)
	localparam int COORD_BITS_DEF = 32;

	// limb width of the partial products inside the wide multiplier
	localparam int LIMB_BITS = 32;

	// register stages of tcc_mul: magnitude, partial products, row sums, total, sign
	localparam int MUL_LAT = 5;

	// status of one result coordinate
	typedef struct packed {
		logic sat;
		logic degen;
	} flags_t;

endpackage

FILE: rtl/tcc_mul.sv
// tcc_mul: pipelined signed multiplier built from limb partial products
// depends on tcc_pkg (LIMB_BITS)
module tcc_mul #(
	parameter int WA = 64,
	parameter int WB = 64
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [WA-1:0]      a,
	input  logic signed [WB-1:0]      b,
	output logic signed [WA+WB-1:0]   p
);
	localparam int LB   = tcc_pkg::LIMB_BITS;
	localparam int KA   = (WA + LB - 1) / LB;
	localparam int KB   = (WB + LB - 1) / LB;
	localparam int PWD  = WA + WB;
	localparam int RWID = (KA + KB) * LB;

	logic [KA*LB-1:0]  ma_s1;
	logic [KB*LB-1:0]  mb_s1;
	logic              neg_s1, neg_s2, neg_s3, neg_s4;
	logic [2*LB-1:0]   pp_s2 [KA*KB];
	logic [RWID-1:0]   row_s3 [KB];
	logic [RWID-1:0]   tot_s4;
	logic [WA-1:0]     abs_a;
	logic [WB-1:0]     abs_b;
	logic [RWID-1:0]   row_c [KB];
	logic [RWID-1:0]   tot_c;

	// operand magnitudes
	always_comb begin
		abs_a = a[WA-1] ? WA'(-a) : WA'(a);
		abs_b = b[WB-1] ? WB'(-b) : WB'(b);
	end

	// row sums and total of the limb products
	always_comb begin
		for (int j = 0; j < KB; j++) begin
			row_c[j] = '0;
			for (int i = 0; i < KA; i++)
				row_c[j] = row_c[j] + (RWID'(pp_s2[i*KB+j]) << (i*LB));
		end
		tot_c = '0;
		for (int j = 0; j < KB; j++)
			tot_c = tot_c + (row_s3[j] << (j*LB));
	end

	// pipeline registers
	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= (KA*LB)'(abs_a);
			mb_s1  <= (KB*LB)'(abs_b);
			neg_s1 <= a[WA-1] ^ b[WB-1];
			for (int i = 0; i < KA; i++)
				for (int j = 0; j < KB; j++)
					pp_s2[i*KB+j] <= (2*LB)'(ma_s1[i*LB +: LB]) *
						(2*LB)'(mb_s1[j*LB +: LB]);
			neg_s2 <= neg_s1;
			row_s3 <= row_c;
			neg_s3 <= neg_s2;
			tot_s4 <= tot_c;
			neg_s4 <= neg_s3;
			p      <= neg_s4 ? -$signed(tot_s4[PWD-1:0]) : $signed(tot_s4[PWD-1:0]);
		end
	end

endmodule

FILE: rtl/tcc_div.sv
// tcc_div: one circumcenter coordinate, base plus rounded num/(2*den), saturated
// depends on tcc_pkg (flags_t); one quotient bit per stage
module tcc_div #(
	parameter int CW = 32,
	parameter int NW = 136,
	parameter int DW = 102
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [NW-1:0]  num,
	input  logic signed [DW-1:0]  den,
	input  logic                  flip,
	input  logic                  degen_in,
	input  logic signed [CW-1:0]  base,
	output logic signed [CW-1:0]  coord,
	output tcc_pkg::flags_t       flags
);
	localparam int QB  = CW + 2;
	localparam int RW  = (NW > DW + 1 + QB) ? NW : DW + 1 + QB;
	localparam int VW  = CW + 3;
	localparam logic signed [VW-1:0] HI  = {{4{1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [VW-1:0] LO  = {{4{1'b1}}, {(CW-1){1'b0}}};
	localparam logic [QB-1:0]        LIM = {1'b1, {(CW+1){1'b0}}};

	logic [NW-1:0]          an;
	logic [DW-1:0]          ad;
	logic [RW-1:0]          r_p, d_p;
	logic                   neg_p, dg_p;
	logic signed [CW-1:0]   base_p;
	logic [RW-1:0]          r_st [QB+1];
	logic [RW-1:0]          d_st [QB+1];
	logic [QB-1:0]          q_st [QB+1];
	logic                   big_st [QB+1];
	logic                   neg_st [QB+1];
	logic                   dg_st [QB+1];
	logic signed [CW-1:0]   base_st [QB+1];
	logic [RW-1:0]          r_nx [QB+1];
	logic [QB-1:0]          q_nx [QB+1];
	logic                   big_nx [QB+1];
	logic signed [VW-1:0]   v;
	logic                   ovf;

	// magnitudes for the rounded division
	always_comb begin
		an = num[NW-1] ? NW'(-num) : NW'(num);
		ad = den[DW-1] ? DW'(-den) : DW'(den);
	end

	// restoring division, first stage checks the quotient range
	always_comb begin
		logic [RW-1:0] shd;
		logic          ge;
		r_nx[0]   = r_p;
		q_nx[0]   = '0;
		big_nx[0] = r_p >= (d_p << QB);
		for (int k = 1; k <= QB; k++) begin
			shd       = d_st[k-1] << (QB - k);
			ge        = r_st[k-1] >= shd;
			r_nx[k]   = ge ? r_st[k-1] - shd : r_st[k-1];
			q_nx[k]   = ge ? (q_st[k-1] | (QB'(1) << (QB - k))) : q_st[k-1];
			big_nx[k] = big_st[k-1];
		end
	end

	// offset, add to base and clip
	always_comb begin
		ovf = big_st[QB] || (q_st[QB] > LIM);
		v = neg_st[QB] ? VW'(base_st[QB]) - $signed({1'b0, q_st[QB]})
			: VW'(base_st[QB]) + $signed({1'b0, q_st[QB]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_p    <= RW'(an) + RW'(ad);
			d_p    <= RW'(ad) << 1;
			neg_p  <= num[NW-1] ^ den[DW-1] ^ flip;
			dg_p   <= degen_in;
			base_p <= base;
			for (int k = 0; k <= QB; k++) begin
				r_st[k]   <= r_nx[k];
				q_st[k]   <= q_nx[k];
				big_st[k] <= big_nx[k];
			end
			d_st[0]    <= d_p;
			neg_st[0]  <= neg_p;
			dg_st[0]   <= dg_p;
			base_st[0] <= base_p;
			for (int k = 1; k <= QB; k++) begin
				d_st[k]    <= d_st[k-1];
				neg_st[k]  <= neg_st[k-1];
				dg_st[k]   <= dg_st[k-1];
				base_st[k] <= base_st[k-1];
			end
			flags.degen <= dg_st[QB];
			if (dg_st[QB]) begin
				coord     <= base_st[QB];
				flags.sat <= 1'b0;
			end else if (ovf) begin
				coord     <= neg_st[QB] ? CW'(LO) : CW'(HI);
				flags.sat <= 1'b1;
			end else if (v > HI) begin
				coord     <= CW'(HI);
				flags.sat <= 1'b1;
			end else if (v < LO) begin
				coord     <= CW'(LO);
				flags.sat <= 1'b1;
			end else begin
				coord     <= CW'(v);
				flags.sat <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/tetrahedron_circumcenter.sv
// tetrahedron_circumcenter: top level, edge vectors, exact determinants, division
// depends on tcc_pkg, tcc_mul and tcc_div
//
// Takes the four vertices of a tetrahedron as one item and returns its
// circumcenter in the same signed fixed-point format (y offset negated), with
// exact integer determinants and round-half-away division. One item is taken
// every cycle unless the output stalls; the divider resolves one quotient bit
// per stage. A zero denominator gives the first vertex with degenerate set;
// clipped coordinates set saturated. The whole pipeline holds while a finished
// item is stalled.
module tetrahedron_circumcenter #(
	parameter int COORD_BITS = tcc_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic signed [COORD_BITS-1:0] ax,
	input  logic signed [COORD_BITS-1:0] ay,
	input  logic signed [COORD_BITS-1:0] az,
	input  logic signed [COORD_BITS-1:0] bx,
	input  logic signed [COORD_BITS-1:0] by_coord,
	input  logic signed [COORD_BITS-1:0] bz,
	input  logic signed [COORD_BITS-1:0] cx,
	input  logic signed [COORD_BITS-1:0] cy,
	input  logic signed [COORD_BITS-1:0] cz,
	input  logic signed [COORD_BITS-1:0] dx,
	input  logic signed [COORD_BITS-1:0] dy,
	input  logic signed [COORD_BITS-1:0] dz,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic signed [COORD_BITS-1:0] center_x,
	output logic signed [COORD_BITS-1:0] center_y,
	output logic signed [COORD_BITS-1:0] center_z,
	output logic                         degenerate,
	output logic                         saturated
);
	localparam int CW  = COORD_BITS;
	localparam int EW  = CW + 1;
	localparam int PW  = 2 * EW;
	localparam int MW  = PW + 1;
	localparam int LW  = PW + 1;
	localparam int NW  = MW + LW + 2;
	localparam int DNW = MW + EW + 2;
	localparam int ML  = tcc_pkg::MUL_LAT;
	localparam int DIV_LAT = CW + 5;
	localparam int LAT = 3 + ML + 1 + DIV_LAT;
	// column pairs of the 2x2 minors: (y,z), (x,z), (x,y)
	localparam int PC0 [3] = '{1, 0, 0};
	localparam int PC1 [3] = '{2, 2, 1};
	// row pairs of the minors: (0,1), (0,2), (1,2)
	localparam int MR0 [3] = '{0, 0, 1};
	localparam int MR1 [3] = '{1, 2, 2};
	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

	logic                  adv;
	logic [LAT-1:0]        vld_q;
	logic signed [CW-1:0]  vin [3][3];
	logic signed [CW-1:0]  ain [3];
	logic signed [EW-1:0]  e_s1 [3][3];
	logic signed [CW-1:0]  a_s1 [3], a_s2 [3], a_s3 [3], a_s9 [3];
	logic signed [CW-1:0]  a_dly [ML][3];
	logic signed [PW-1:0]  pa_s2 [3][3];
	logic signed [PW-1:0]  pb_s2 [3][3];
	logic signed [PW-1:0]  sq_s2 [3][3];
	logic signed [EW-1:0]  ez_s2 [3];
	logic signed [MW-1:0]  mn_s3 [3][3];
	logic signed [LW-1:0]  len_s3 [3];
	logic signed [EW-1:0]  ez_s3 [3];
	logic signed [MW+LW-1:0] tn [3][3];
	logic signed [MW+EW-1:0] td [3];
	logic signed [NW-1:0]  num_s9 [3];
	logic signed [DNW-1:0] den_s9;
	logic signed [CW-1:0]  cen [3];
	tcc_pkg::flags_t       flg [3];

	// the whole pipeline advances unless a finished item is held
	assign adv        = !vld_q[LAT-1] || !result_stall;
	assign item_stall = !adv;

	always_comb begin
		ain = '{ax, ay, az};
		vin = '{'{bx, by_coord, bz}, '{cx, cy, cz}, '{dx, dy, dz}};
	end

	// valid bits travel with the items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], item_valid};
		end
	end

	// edge vectors, products, minors, squared lengths and cofactor sums
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				for (int k = 0; k < 3; k++)
					e_s1[i][k] <= EW'(vin[i][k]) - EW'(ain[k]);
			a_s1 <= ain;
			for (int p = 0; p < 3; p++)
				for (int m = 0; m < 3; m++) begin
					pa_s2[p][m] <= PW'(e_s1[MR0[m]][PC0[p]]) * PW'(e_s1[MR1[m]][PC1[p]]);
					pb_s2[p][m] <= PW'(e_s1[MR1[m]][PC0[p]]) * PW'(e_s1[MR0[m]][PC1[p]]);
				end
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++)
					sq_s2[i][k] <= PW'(e_s1[i][k]) * PW'(e_s1[i][k]);
				ez_s2[i] <= e_s1[i][2];
			end
			a_s2 <= a_s1;
			for (int p = 0; p < 3; p++)
				for (int m = 0; m < 3; m++)
					mn_s3[p][m] <= MW'(pa_s2[p][m]) - MW'(pb_s2[p][m]);
			for (int i = 0; i < 3; i++)
				len_s3[i] <= LW'(sq_s2[i][0]) + LW'(sq_s2[i][1]) + LW'(sq_s2[i][2]);
			ez_s3 <= ez_s2;
			a_s3  <= a_s2;
			a_dly[0] <= a_s3;
			for (int s = 1; s < ML; s++)
				a_dly[s] <= a_dly[s-1];
			// cofactor sums: m01*c(row2) - m02*c(row1) + m12*c(row0)
			for (int d = 0; d < 3; d++)
				num_s9[d] <= NW'(tn[d][0]) - NW'(tn[d][1]) + NW'(tn[d][2]);
			den_s9 <= DNW'(td[0]) - DNW'(td[1]) + DNW'(td[2]);
			a_s9   <= a_dly[ML-1];
		end
	end

	// minor times third column, numerators use squared lengths
	for (genvar d = 0; d < 3; d++) begin : g_num
		for (genvar t = 0; t < 3; t++) begin : g_term
			tcc_mul #(.WA(MW), .WB(LW)) u_mul (
				.clk (clk),
				.en  (adv),
				.a   (mn_s3[d][t]),
				.b   (len_s3[2-t]),
				.p   (tn[d][t])
			);
		end
	end

	// denominator uses the (x,y) minors and the z column
	for (genvar t = 0; t < 3; t++) begin : g_den
		tcc_mul #(.WA(MW), .WB(EW)) u_mul (
			.clk (clk),
			.en  (adv),
			.a   (mn_s3[2][t]),
			.b   (ez_s3[2-t]),
			.p   (td[t])
		);
	end

	// one divider per coordinate, y offset negated
	for (genvar c = 0; c < 3; c++) begin : g_div
		tcc_div #(.CW(CW), .NW(NW), .DW(DNW)) u_div (
			.clk      (clk),
			.en       (adv),
			.num      (num_s9[c]),
			.den      (den_s9),
			.flip     (c == 1),
			.degen_in (den_s9 == '0),
			.base     (a_s9[c]),
			.coord    (cen[c]),
			.flags    (flg[c])
		);
	end

	assign result_valid = vld_q[LAT-1];
	assign center_x     = cen[0];
	assign center_y     = cen[1];
	assign center_z     = cen[2];
	assign degenerate   = flg[0].degen;
	assign saturated    = flg[0].sat | flg[1].sat | flg[2].sat;

	// a flat tetrahedron never reports clipping
	a_degen_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && degenerate |-> !saturated)
		else $error("degenerate item reports saturation");

	// clipping leaves at least one coordinate at a range limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |->
			(center_x == CMAX || center_x == CMIN || center_y == CMAX ||
			 center_y == CMIN || center_z == CMAX || center_z == CMIN))
		else $error("saturated item has no coordinate at a limit");

endmodule

FILE: tb/tb_tetrahedron_circumcenter.sv
// tb_tetrahedron_circumcenter: self-checking testbench for tetrahedron_circumcenter
// depends on tcc_pkg and the tetrahedron_circumcenter rtl; exact-integer predictor inside
module tb_tetrahedron_circumcenter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = tcc_pkg::COORD_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 80;

	typedef logic signed [CB-1:0] coord_t;
	typedef coord_t tet_t [12];
	typedef logic signed [255:0] wide_t;

	typedef struct packed {
		coord_t cx;
		coord_t cy;
		coord_t cz;
		logic   degen;
		logic   sat;
	} center_t;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	coord_t vert [12];
	logic result_valid;
	logic result_stall;
	coord_t center_x, center_y, center_z;
	logic degenerate, saturated;

	center_t expected_centers [$];
	int errors;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	int quiet_cycles;

	tetrahedron_circumcenter u_top (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.ax(vert[0]), .ay(vert[1]), .az(vert[2]),
		.bx(vert[3]), .by_coord(vert[4]), .bz(vert[5]),
		.cx(vert[6]), .cy(vert[7]), .cz(vert[8]),
		.dx(vert[9]), .dy(vert[10]), .dz(vert[11]),
		.result_valid(result_valid), .result_stall(result_stall),
		.center_x(center_x), .center_y(center_y), .center_z(center_z),
		.degenerate(degenerate), .saturated(saturated)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// 3x3 determinant, exact in 256 bits
	function automatic wide_t det3(input wide_t m [9]);
		wide_t m01, m02, m12;
		m01 = m[0] * m[4] - m[3] * m[1];
		m02 = m[0] * m[7] - m[6] * m[1];
		m12 = m[3] * m[7] - m[6] * m[4];
		return m01 * m[8] - m02 * m[5] + m12 * m[2];
	endfunction

	// base plus rounded num/(2*den), clipped to the coordinate range
	function automatic coord_t offset_coord(input coord_t base, input wide_t num,
		input wide_t den, input logic flip, inout logic sat);
		logic neg;
		logic [255:0] an, ad, q;
		logic signed [63:0] v, hi, lo;
		hi = (64'sd1 <<< (CB - 1)) - 1;
		lo = -(64'sd1 <<< (CB - 1));
		neg = num[255] ^ den[255] ^ flip;
		an = num[255] ? -num : num;
		ad = den[255] ? -den : den;
		q = (an + ad) / (ad << 1);
		if (q > (256'd1 << (CB + 1))) begin
			sat = 1'b1;
			return neg ? coord_t'(lo) : coord_t'(hi);
		end
		v = base;
		v = neg ? v - $signed({1'b0, q[62:0]}) : v + $signed({1'b0, q[62:0]});
		if (v > hi) begin
			sat = 1'b1;
			return coord_t'(hi);
		end
		if (v < lo) begin
			sat = 1'b1;
			return coord_t'(lo);
		end
		return coord_t'(v);
	endfunction

	// circumcenter of one tetrahedron
	function automatic center_t circumcenter(input tet_t p);
		wide_t e [3][3];
		wide_t l2 [3];
		wide_t m [9];
		wide_t av, nx, ny, nz, dn;
		center_t r;
		logic sat;
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				av = p[k];
				e[i][k] = p[3 + 3 * i + k];
				e[i][k] = e[i][k] - av;
			end
			l2[i] = e[i][0] * e[i][0] + e[i][1] * e[i][1] + e[i][2] * e[i][2];
		end
		for (int i = 0; i < 3; i++) begin
			m[3*i] = e[i][1]; m[3*i+1] = e[i][2]; m[3*i+2] = l2[i];
		end
		nx = det3(m);
		for (int i = 0; i < 3; i++) begin
			m[3*i] = e[i][0]; m[3*i+1] = e[i][2]; m[3*i+2] = l2[i];
		end
		ny = det3(m);
		for (int i = 0; i < 3; i++) begin
			m[3*i] = e[i][0]; m[3*i+1] = e[i][1]; m[3*i+2] = l2[i];
		end
		nz = det3(m);
		for (int i = 0; i < 3; i++) begin
			m[3*i] = e[i][0]; m[3*i+1] = e[i][1]; m[3*i+2] = e[i][2];
		end
		dn = det3(m);
		if (dn == 0) begin
			r = '{cx: p[0], cy: p[1], cz: p[2], degen: 1'b1, sat: 1'b0};
			return r;
		end
		sat = 1'b0;
		r.cx = offset_coord(p[0], nx, dn, 1'b0, sat);
		r.cy = offset_coord(p[1], ny, dn, 1'b1, sat);
		r.cz = offset_coord(p[2], nz, dn, 1'b0, sat);
		r.degen = 1'b0;
		r.sat = sat;
		return r;
	endfunction

	// offer one item, wait for acceptance, then idle at random
	task automatic send_tet(input tet_t p);
		item_valid <= 1'b1;
		foreach (p[i]) vert[i] <= p[i];
		do @(posedge clk); while (item_stall);
		expected_centers.push_back(circumcenter(p));
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	function automatic coord_t rand_coord(input int bits);
		coord_t c;
		c = $urandom;
		if (bits < CB) c = c >>> (CB - bits);
		return c;
	endfunction

	// random tetrahedron: mostly well-formed, some flat, some extreme
	function automatic tet_t rand_tet();
		tet_t p;
		int kind, bits;
		kind = $urandom_range(9);
		case (kind)
			0, 1, 2, 3: bits = 14;
			4: bits = 3;
			5: bits = CB;
			8: bits = 25;
			default: bits = 18;
		endcase
		foreach (p[i]) p[i] = rand_coord(bits);
		if (kind == 9) begin
			for (int k = 0; k < 3; k++) begin
				p[3 + k] = p[k] + rand_coord(10);
				p[6 + k] = p[k] + rand_coord(10);
				p[9 + k] = p[k] + rand_coord(10);
			end
		end
		if (kind == 6) begin
			int src, dst;
			src = $urandom_range(3);
			dst = (src + 1 + $urandom_range(2)) % 4;
			for (int k = 0; k < 3; k++) p[3 * dst + k] = p[3 * src + k];
		end
		if (kind == 7) begin
			for (int i = 1; i < 4; i++) p[3 * i + 2] = p[2];
		end
		return p;
	endfunction

	task automatic test_directed();
		coord_t one, mx, mn;
		tet_t cases [$];
		one = coord_t'(1) <<< 16;
		mx = {1'b0, {(CB-1){1'b1}}};
		mn = {1'b1, {(CB-1){1'b0}}};
		// all points coincide
		cases.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
		// unit corner tetrahedron
		cases.push_back('{0, 0, 0, one, 0, 0, 0, one, 0, 0, 0, one});
		// same, shifted negative so the negated y offset shows
		cases.push_back('{-one, -3*one, 2*one, 0, -3*one, 2*one, -one, -2*one, 2*one,
			-one, -3*one, 3*one});
		// coplanar points
		cases.push_back('{0, 0, 5, one, 0, 5, 0, one, 5, one, one, 5});
		// collinear points
		cases.push_back('{0, 0, 0, one, one, one, 2*one, 2*one, 2*one, -one, -one, -one});
		// extreme corners of the coordinate range
		cases.push_back('{mn, mn, mn, mx, mn, mn, mn, mx, mn, mn, mn, mx});
		cases.push_back('{mx, mx, mx, mn, mx, mx, mx, mn, mx, mx, mx, mn});
		cases.push_back('{mx, mn, mx, mn, mx, mn, mx, mx, mn, mn, mn, mx});
		// every field at max, every field at min
		cases.push_back('{mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx});
		cases.push_back('{mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn});
		// nearly flat, center far away and clipped
		cases.push_back('{0, 0, 0, mx, 0, 0, 0, mx, 0, mx, mx, 1});
		cases.push_back('{0, 0, 0, mx, 0, 0, 0, mx, 0, mn, mn, -1});
		// smallest nonzero edges, rounding ties
		cases.push_back('{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1});
		cases.push_back('{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, -1});
		cases.push_back('{3, -2, 1, 4, -2, 1, 3, -1, 1, 3, -2, 3});
		// large base with small offset near the top and the bottom of range
		cases.push_back('{mx, mx, mx, mx - 2, mx, mx, mx, mx - 2, mx, mx, mx, mx - 2});
		cases.push_back('{mn, mn, mn, mn + 2, mn, mn, mn, mn + 2, mn, mn, mn, mn + 2});
		foreach (cases[i]) send_tet(cases[i]);
	endtask

	task automatic test_random(input int n, input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		repeat (n) send_tet(rand_tet());
	endtask

	// long receiver hold while the sender keeps offering items
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = 150;
		repeat (70) send_tet(rand_tet());
	endtask

	// receiver stall, with an optional long hold
	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// result check against the oldest expected center
	always @(posedge clk) begin
		center_t exp_c;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_centers.size() == 0) begin
				$error("unexpected item: center_x=%0d center_y=%0d center_z=%0d",
					center_x, center_y, center_z);
				errors++;
			end else begin
				exp_c = expected_centers.pop_front();
				if (center_x !== exp_c.cx) begin
					$error("center_x expected %0d actual %0d", exp_c.cx, center_x);
					errors++;
				end
				if (center_y !== exp_c.cy) begin
					$error("center_y expected %0d actual %0d", exp_c.cy, center_y);
					errors++;
				end
				if (center_z !== exp_c.cz) begin
					$error("center_z expected %0d actual %0d", exp_c.cz, center_z);
					errors++;
				end
				if (degenerate !== exp_c.degen) begin
					$error("degenerate expected %0b actual %0b", exp_c.degen, degenerate);
					errors++;
				end
				if (saturated !== exp_c.sat) begin
					$error("saturated expected %0b actual %0b", exp_c.sat, saturated);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// test sequence
	initial begin
		errors = 0;
		quiet_cycles = 0;
		hold_left = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		result_stall = 1'b0;
		foreach (vert[i]) vert[i] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(155, 38, 71);
		test_random(155, 71, 38);
		test_backpressure();
		test_random(155, 0, 0);
		item_valid <= 1'b0;
		wait (expected_centers.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
